// ===== rtl/huffman_build_encode_decode_core_assert.svh =====
// Assertion macros used by the codec datapath RTL.
`ifndef HUFFMAN_BUILD_ENCODE_DECODE_CORE_ASSERT_SVH
`define HUFFMAN_BUILD_ENCODE_DECODE_CORE_ASSERT_SVH

// Same-cycle implication.
`define HBED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbed assertion failed");

// Next-cycle implication.
`define HBED_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbed assertion failed");

`endif

// ===== rtl/hbed_pkg.sv =====
// ----------------------------------------------------------------------------
// hbed_pkg
// Types, codes and constants of the byte Huffman codec.
// ----------------------------------------------------------------------------
package hbed_pkg;

  localparam int LEAF_SLOTS  = 256;
  localparam int NODE_SLOTS  = 511;
  localparam int NODE_W      = 9;
  localparam int SYM_W       = 8;
  localparam int WORD_W      = 32;
  localparam int LEN_W       = 6;
  localparam int CODE_ENT_W  = WORD_W + LEN_W;
  localparam int CHILD_W     = 2 * NODE_W;

  localparam int ALPHABET_SIZE_DEF = 256;
  localparam int COUNT_BITS_DEF    = 16;
  localparam int MAX_CODE_BITS_DEF = 32;

  localparam logic [NODE_W-1:0] LEAF_NODE  = NODE_W'(LEAF_SLOTS);
  localparam logic [NODE_W-1:0] NODE_LIMIT = NODE_W'(NODE_SLOTS);

  typedef enum logic [1:0] {
    ACT_COUNT  = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_DECODE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_CODE   = 2'd0,
    ST_SYMBOL = 2'd1,
    ST_ABSENT = 2'd2,
    ST_NOTREE = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CNT_RD,
    OP_CNT_WR,
    OP_SW_INIT,
    OP_SW_RD,
    OP_SW_WR,
    OP_SC_INIT,
    OP_SC_RD,
    OP_SC_CMP,
    OP_MERGE,
    OP_ROOT,
    OP_CG_RD,
    OP_CG_WA,
    OP_CG_WB,
    OP_FINISH,
    OP_ENC_RD,
    OP_ENC_OUT,
    OP_DEC_RD,
    OP_DEC_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    action_e act;
    logic    last;
    logic    sw_last;
    logic    more_merge;
    logic    scan_last;
    logic    tree_end;
    logic    cg_last;
    logic    out_busy;
  } stat_t;

endpackage

// ===== rtl/hbed_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbed_ctrl
// Sequencer: dispatches items and steps the tree build.
// ----------------------------------------------------------------------------
module hbed_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hbed_pkg::stat_t stat_i,
  output hbed_pkg::cmd_t  cmd_o
);
  import hbed_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_CNT_RD, S_CNT_WR, S_SW_INIT, S_SW_RD, S_SW_WR,
    S_DECIDE, S_SC_INIT, S_SC_RD, S_SC_CMP, S_MERGE, S_ROOT, S_CG_RD,
    S_CG_WA, S_CG_WB, S_FINISH, S_ENC_RD, S_ENC_OUT, S_DEC_RD, S_DEC_OUT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.act)
          ACT_COUNT:  state_d = S_CNT_RD;
          ACT_ENCODE: state_d = S_ENC_RD;
          ACT_DECODE: state_d = S_DEC_RD;
          default:    state_d = S_IDLE;
        endcase
      end
      S_CNT_RD: begin
        cmd_o.op = OP_CNT_RD;
        state_d  = S_CNT_WR;
      end
      S_CNT_WR: begin
        cmd_o.op = OP_CNT_WR;
        state_d  = stat_i.last ? S_SW_INIT : S_IDLE;
      end
      S_SW_INIT: begin
        cmd_o.op = OP_SW_INIT;
        state_d  = S_SW_RD;
      end
      S_SW_RD: begin
        cmd_o.op = OP_SW_RD;
        state_d  = S_SW_WR;
      end
      S_SW_WR: begin
        cmd_o.op = OP_SW_WR;
        state_d  = stat_i.sw_last ? S_DECIDE : S_SW_RD;
      end
      S_DECIDE: begin
        state_d = stat_i.more_merge ? S_SC_INIT : S_ROOT;
      end
      S_SC_INIT: begin
        cmd_o.op = OP_SC_INIT;
        state_d  = S_SC_RD;
      end
      S_SC_RD: begin
        cmd_o.op = OP_SC_RD;
        state_d  = S_SC_CMP;
      end
      S_SC_CMP: begin
        cmd_o.op = OP_SC_CMP;
        state_d  = stat_i.scan_last ? S_MERGE : S_SC_RD;
      end
      S_MERGE: begin
        cmd_o.op = OP_MERGE;
        state_d  = S_DECIDE;
      end
      S_ROOT: begin
        cmd_o.op = OP_ROOT;
        state_d  = stat_i.tree_end ? S_IDLE : S_CG_RD;
      end
      S_CG_RD: begin
        cmd_o.op = OP_CG_RD;
        state_d  = S_CG_WA;
      end
      S_CG_WA: begin
        cmd_o.op = OP_CG_WA;
        state_d  = S_CG_WB;
      end
      S_CG_WB: begin
        cmd_o.op = OP_CG_WB;
        state_d  = stat_i.cg_last ? S_FINISH : S_CG_RD;
      end
      S_FINISH: begin
        cmd_o.op = OP_FINISH;
        state_d  = S_IDLE;
      end
      S_ENC_RD: begin
        cmd_o.op = OP_ENC_RD;
        state_d  = S_ENC_OUT;
      end
      S_ENC_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_ENC_OUT;
          state_d  = S_IDLE;
        end
      end
      S_DEC_RD: begin
        cmd_o.op = OP_DEC_RD;
        state_d  = S_DEC_OUT;
      end
      S_DEC_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_DEC_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/hbed_dp.sv =====
// ----------------------------------------------------------------------------
// hbed_dp
// Tables, tree build datapath and result register.
// ----------------------------------------------------------------------------
`include "huffman_build_encode_decode_core_assert.svh"

module hbed_dp #(
  parameter int ALPHABET_SIZE = hbed_pkg::ALPHABET_SIZE_DEF,
  parameter int COUNT_BITS    = hbed_pkg::COUNT_BITS_DEF,
  parameter int MAX_CODE_BITS = hbed_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hbed_pkg::cmd_t              cmd_i,
  output hbed_pkg::stat_t             stat_o,
  input  logic [1:0]                  action_i,
  input  logic [hbed_pkg::SYM_W-1:0]  symbol_i,
  input  logic                        code_bit_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [hbed_pkg::WORD_W-1:0] code_word_o,
  output logic [hbed_pkg::LEN_W-1:0]  code_length_o,
  output logic [hbed_pkg::SYM_W-1:0]  decoded_symbol_o
);
  import hbed_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [NODE_W-1:0] ALPHA_LIM = NODE_W'(ALPHABET_SIZE);
  localparam logic [NODE_W-1:0] LEAF_LAST = NODE_W'(LEAF_SLOTS - 1);

  // Storage
  logic [COUNT_BITS-1:0] cnt_mem [LEAF_SLOTS];
  logic [COUNT_BITS-1:0] wt_mem  [NODE_SLOTS];
  logic [CHILD_W-1:0]    ch_mem  [LEAF_SLOTS-1];
  logic [CODE_ENT_W-1:0] iw_mem  [LEAF_SLOTS-1];
  logic [CODE_ENT_W-1:0] cd_mem  [LEAF_SLOTS];

  logic [COUNT_BITS-1:0] cnt_rd_q, wt_rd_q;
  logic [CHILD_W-1:0]    ch_rd_q;
  logic [CODE_ENT_W-1:0] iw_rd_q, cd_rd_q;

  // Control state
  logic                  tree_ready_q, pass_open_q, out_valid_q;
  logic [COUNT_BITS-1:0] pass_total_q;
  logic [NODE_W-1:0]     root_q, decode_q;
  logic [LEAF_SLOTS-1:0] present_q, cnt_vld_q;

  // Working registers
  action_e               act_q;
  logic [SYM_W-1:0]      sym_q;
  logic                  bit_q, last_q;
  logic [NODE_W-1:0]     idx_q;
  logic [SYM_W-1:0]      made_q, k_q, lastleaf_q;
  logic [NODE_W-1:0]     leaves_q;
  logic [NODE_SLOTS-1:0] live_q;
  logic [NODE_W-1:0]     b1_q, b2_q;
  logic [COUNT_BITS-1:0] w1_q, w2_q;
  logic                  b1v_q, b2v_q;
  status_e               out_status_q;
  logic [WORD_W-1:0]     out_word_q;
  logic [LEN_W-1:0]      out_len_q;
  logic [SYM_W-1:0]      out_sym_q;

  // Derived
  logic                  cnt_ok, here, root_int;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [NODE_W-1:0]     new_node, dec_sel, dec_nxt, child;
  logic [WORD_W-1:0]     par_word, ch_word;
  logic [LEN_W-1:0]      par_len, ch_len;
  logic                  out_busy;

  assign cnt_ok   = ({1'b0, sym_q} < ALPHA_LIM) && (pass_total_q != COUNT_MAX);
  assign cnt_inc  = (cnt_vld_q[sym_q] ? cnt_rd_q : '0) + COUNT_BITS'(1);
  assign here     = (idx_q < ALPHA_LIM) && cnt_vld_q[idx_q[SYM_W-1:0]] && (cnt_rd_q != '0);
  assign new_node = LEAF_NODE + {1'b0, made_q};
  assign root_int = (root_q >= LEAF_NODE);
  assign dec_sel  = ((decode_q >= LEAF_NODE) && (decode_q < NODE_LIMIT)) ? decode_q : root_q;
  assign dec_nxt  = bit_q ? ch_rd_q[NODE_W-1:0] : ch_rd_q[CHILD_W-1:NODE_W];

  // Code generation: the root, as the first parent, has an empty code
  assign par_word = (k_q == made_q) ? '0 : iw_rd_q[WORD_W-1:0];
  assign par_len  = (k_q == made_q) ? '0 : iw_rd_q[CODE_ENT_W-1:WORD_W];
  assign ch_len   = (par_len == '1) ? par_len : par_len + LEN_W'(1);
  assign child    = (cmd_i.op == OP_CG_WA) ? ch_rd_q[CHILD_W-1:NODE_W] : ch_rd_q[NODE_W-1:0];
  assign ch_word  = {par_word[WORD_W-2:0], (cmd_i.op == OP_CG_WB)};

  assign out_busy = out_valid_q && !out_ready_i;

  assign stat_o.act        = act_q;
  assign stat_o.last       = last_q;
  assign stat_o.sw_last    = (idx_q == LEAF_LAST);
  assign stat_o.more_merge = (({1'b0, made_q} + NODE_W'(1)) < leaves_q);
  assign stat_o.scan_last  = (idx_q == (LEAF_LAST + {1'b0, made_q}));
  assign stat_o.tree_end   = (leaves_q == '0) || (made_q == '0);
  assign stat_o.cg_last    = (k_q == SYM_W'(1));
  assign stat_o.out_busy   = out_busy;

  // Histogram memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CNT_WR && cnt_ok) begin
      cnt_mem[sym_q] <= cnt_inc;
    end
    if (cmd_i.op == OP_CNT_RD) begin
      cnt_rd_q <= cnt_mem[sym_q];
    end else if (cmd_i.op == OP_SW_RD) begin
      cnt_rd_q <= cnt_mem[idx_q[SYM_W-1:0]];
    end
  end

  // Node weight memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SW_WR) begin
      wt_mem[idx_q] <= here ? cnt_rd_q : '0;
    end else if (cmd_i.op == OP_MERGE) begin
      wt_mem[new_node] <= w1_q + w2_q;
    end
    if (cmd_i.op == OP_SC_RD) begin
      wt_rd_q <= wt_mem[idx_q];
    end
  end

  // Child pair memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MERGE) begin
      ch_mem[made_q] <= {b1_q, b2_q};
    end
    if (cmd_i.op == OP_CG_RD) begin
      ch_rd_q <= ch_mem[k_q - SYM_W'(1)];
    end else if (cmd_i.op == OP_DEC_RD) begin
      ch_rd_q <= ch_mem[dec_sel[SYM_W-1:0]];
    end
  end

  // Internal node code memory
  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == OP_CG_WA || cmd_i.op == OP_CG_WB) && child[NODE_W-1]) begin
      iw_mem[child[SYM_W-1:0]] <= {ch_len, ch_word};
    end
    if (cmd_i.op == OP_CG_RD) begin
      iw_rd_q <= iw_mem[k_q - SYM_W'(1)];
    end
  end

  // Leaf code memory
  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == OP_CG_WA || cmd_i.op == OP_CG_WB) && !child[NODE_W-1]) begin
      cd_mem[child[SYM_W-1:0]] <= {ch_len, ch_word};
    end else if (cmd_i.op == OP_ROOT && leaves_q != '0 && made_q == '0) begin
      cd_mem[lastleaf_q] <= '0;
    end
    if (cmd_i.op == OP_ENC_RD) begin
      cd_rd_q <= cd_mem[sym_q];
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        act_q  <= action_e'(action_i);
        sym_q  <= symbol_i;
        bit_q  <= code_bit_i;
        last_q <= last_i;
      end
      OP_SW_INIT: begin
        idx_q    <= '0;
        made_q   <= '0;
        leaves_q <= '0;
        live_q   <= '0;
      end
      OP_SW_WR: begin
        live_q[idx_q] <= here;
        if (here) begin
          leaves_q   <= leaves_q + NODE_W'(1);
          lastleaf_q <= idx_q[SYM_W-1:0];
        end
        idx_q <= idx_q + NODE_W'(1);
      end
      OP_SC_INIT: begin
        idx_q <= '0;
        b1v_q <= 1'b0;
        b2v_q <= 1'b0;
      end
      OP_SC_CMP: begin
        // strict compare keeps the lower key on ties
        if (live_q[idx_q]) begin
          if (!b1v_q || wt_rd_q < w1_q) begin
            b2_q  <= b1_q;
            w2_q  <= w1_q;
            b2v_q <= b1v_q;
            b1_q  <= idx_q;
            w1_q  <= wt_rd_q;
            b1v_q <= 1'b1;
          end else if (!b2v_q || wt_rd_q < w2_q) begin
            b2_q  <= idx_q;
            w2_q  <= wt_rd_q;
            b2v_q <= 1'b1;
          end
        end
        idx_q <= idx_q + NODE_W'(1);
      end
      OP_MERGE: begin
        live_q[b1_q]     <= 1'b0;
        live_q[b2_q]     <= 1'b0;
        live_q[new_node] <= 1'b1;
        made_q           <= made_q + SYM_W'(1);
      end
      OP_ROOT: begin
        k_q <= made_q;
      end
      OP_CG_WB: begin
        k_q <= k_q - SYM_W'(1);
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_ready_q <= 1'b0;
      pass_open_q  <= 1'b0;
      pass_total_q <= '0;
      root_q       <= '0;
      decode_q     <= '0;
      present_q    <= '0;
      cnt_vld_q    <= '0;
    end else begin
      case (cmd_i.op)
        OP_CNT_RD: begin
          if (!pass_open_q) begin
            cnt_vld_q    <= '0;
            pass_total_q <= '0;
            pass_open_q  <= 1'b1;
          end
        end
        OP_CNT_WR: begin
          if (cnt_ok) begin
            cnt_vld_q[sym_q] <= 1'b1;
            pass_total_q     <= pass_total_q + COUNT_BITS'(1);
          end
        end
        OP_SW_WR: begin
          present_q[idx_q[SYM_W-1:0]] <= here;
        end
        OP_ROOT: begin
          if (leaves_q == '0) begin
            tree_ready_q <= 1'b0;
            root_q       <= '0;
            decode_q     <= '0;
            pass_open_q  <= 1'b0;
          end else if (made_q == '0) begin
            tree_ready_q <= 1'b1;
            root_q       <= {1'b0, lastleaf_q};
            decode_q     <= {1'b0, lastleaf_q};
            pass_open_q  <= 1'b0;
          end else begin
            root_q <= new_node - NODE_W'(1);
          end
        end
        OP_FINISH: begin
          tree_ready_q <= 1'b1;
          decode_q     <= root_q;
          pass_open_q  <= 1'b0;
        end
        OP_DEC_OUT: begin
          if (tree_ready_q && root_int) begin
            decode_q <= dec_nxt[NODE_W-1] ? dec_nxt : root_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_ENC_OUT) begin
      out_valid_q <= 1'b1;
    end else if (cmd_i.op == OP_DEC_OUT) begin
      out_valid_q <= !(tree_ready_q && root_int && dec_nxt[NODE_W-1]);
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ENC_OUT) begin
      out_sym_q <= '0;
      if (!tree_ready_q) begin
        out_status_q <= ST_NOTREE;
        out_word_q   <= '0;
        out_len_q    <= '0;
      end else if (!present_q[sym_q] ||
                   cd_rd_q[CODE_ENT_W-1:WORD_W] > LEN_W'(MAX_CODE_BITS)) begin
        out_status_q <= ST_ABSENT;
        out_word_q   <= '0;
        out_len_q    <= '0;
      end else begin
        out_status_q <= ST_CODE;
        out_word_q   <= cd_rd_q[WORD_W-1:0];
        out_len_q    <= cd_rd_q[CODE_ENT_W-1:WORD_W];
      end
    end else if (cmd_i.op == OP_DEC_OUT) begin
      out_word_q <= '0;
      out_len_q  <= '0;
      if (!tree_ready_q) begin
        out_status_q <= ST_NOTREE;
        out_sym_q    <= '0;
      end else if (!root_int) begin
        out_status_q <= ST_SYMBOL;
        out_sym_q    <= root_q[SYM_W-1:0];
      end else begin
        out_status_q <= ST_SYMBOL;
        out_sym_q    <= dec_nxt[SYM_W-1:0];
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign code_word_o      = out_word_q;
  assign code_length_o    = out_len_q;
  assign decoded_symbol_o = out_sym_q;

  `HBED_ASSERT_IMP(a_emit_slot_free, clk_i, rst_ni, (cmd_i.op == OP_ENC_OUT || cmd_i.op == OP_DEC_OUT), !out_busy)
  `HBED_ASSERT_IMP(a_merge_two, clk_i, rst_ni, cmd_i.op == OP_MERGE, b1v_q && b2v_q && (b1_q != b2_q))
  `HBED_ASSERT_NXT(a_build_done, clk_i, rst_ni, cmd_i.op == OP_FINISH, tree_ready_q && (decode_q == root_q) && !pass_open_q)

endmodule

// ===== rtl/huffman_build_encode_decode_core.sv =====
// ----------------------------------------------------------------------------
// huffman_build_encode_decode_core: byte Huffman codec. Encode/decode results go to the result register, one item at a time.
// Tree build on the last count: a leaf sweep, then a scan of the live nodes per merge, then codes per internal node.
// Reset clears control state at once; no tree is present and no clearing pass runs.
// ----------------------------------------------------------------------------
module huffman_build_encode_decode_core #(
  parameter int ALPHABET_SIZE = hbed_pkg::ALPHABET_SIZE_DEF,
  parameter int COUNT_BITS    = hbed_pkg::COUNT_BITS_DEF,
  parameter int MAX_CODE_BITS = hbed_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [hbed_pkg::SYM_W-1:0]  symbol_i,
  input  logic                        code_bit_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [hbed_pkg::WORD_W-1:0] code_word_o,
  output logic [hbed_pkg::LEN_W-1:0]  code_length_o,
  output logic [hbed_pkg::SYM_W-1:0]  decoded_symbol_o
);
  import hbed_pkg::*;

  // The sequencer owns the handshake on the input side; the datapath
  // owns all tables and the result register, so a finished result can
  // wait for its transfer while the next item is taken in.
  cmd_t  cmd;
  stat_t stat;

  hbed_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Build: leaf sweep loads weights, each merge scans live nodes once for
  // the two lightest (lower key wins ties), then codes are handed down
  // from the root, two children per internal node.
  hbed_dp #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_BITS    (COUNT_BITS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .action_i         (action_i),
    .symbol_i         (symbol_i),
    .code_bit_i       (code_bit_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .code_word_o      (code_word_o),
    .code_length_o    (code_length_o),
    .decoded_symbol_o (decoded_symbol_o)
  );

endmodule
